>>> rtl/tuvbi_pkg.sv
// ----------------------------------------------------------------------------
// tuvbi_pkg
// Shared types and constants of the triangle UV barycentric interpolator.
// ----------------------------------------------------------------------------
package tuvbi_pkg;

   typedef enum logic [1:0] {
      OP_LOAD_VERTEX = 2'd0,
      OP_LOAD_COORD  = 2'd1,
      OP_LOAD_CORNER = 2'd2,
      OP_QUERY       = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_FACE = 3'd1,
      ST_NO_SET   = 3'd2,
      ST_BAD_REF  = 3'd3,
      ST_DEGEN    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      REG_VERTEX_COUNT = 2'd0,
      REG_FACE_COUNT   = 2'd1,
      REG_SET_MASK     = 2'd2,
      REG_DEGEN_LIMIT  = 2'd3
   } reg_type;

   // floor(i/3) = (i * DIV3_MUL) >> DIV3_SHIFT for any 12-bit i
   localparam int DIV3_MUL   = 2731;
   localparam int DIV3_SHIFT = 13;

   typedef struct packed {
      logic [1:0]         operation;
      logic [11:0]        entry_index;
      logic [1:0]         coord_set;
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic signed [31:0] value_z;
      logic [15:0]        vertex_ref;
      logic signed [31:0] face_number;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] u_out;
      logic signed [31:0] v_out;
   } rsp_type;

endpackage

>>> rtl/triangle_uv_barycentric_interp.sv
// ----------------------------------------------------------------------------
// triangle_uv_barycentric_interp
// Triangle texture-coordinate interpolation by barycentric weights over
// loaded vertex, corner and coordinate tables.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_ready   | req_data (req_type)
//  rsp     | out       | rsp_valid / rsp_ready   | rsp_data (rsp_type)
//  csr     | in/out    | psel, penable, pready   | paddr, pwdata, prdata
//
//  One item per cycle; a query result passes the table reads, the edge and
//  dot-product registers, the multipliers and the 1-bit-per-stage divider.
//  A held result freezes the whole pipeline; req_ready drops with it.
//  Synchronous reset clears valids and configuration registers; tables are
//  not cleared.
// ----------------------------------------------------------------------------
module triangle_uv_barycentric_interp
   import tuvbi_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_FACES    = 1024,
   parameter int COORD_SETS   = 4,
   parameter int COORD_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int FW    = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int SETW  = (COORD_SETS > 1) ? $clog2(COORD_SETS) : 1;
   localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int NUM_W = 172;
   localparam int DEN_W = 137;
   localparam int DL    = SAT_W + 3;
   localparam int NST   = 11 + DL;

   // configuration
   logic [10:0] vertex_count_ff;
   logic [10:0] face_count_ff;
   logic [3:0]  set_mask_ff;
   logic [31:0] degen_limit_ff;
   logic        csr_wr;
   reg_type     reg_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign reg_sel = reg_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
         face_count_ff   <= '0;
         set_mask_ff     <= '0;
         degen_limit_ff  <= '0;
      end else if (csr_wr) begin
         case (reg_sel)
            REG_VERTEX_COUNT: vertex_count_ff <= pwdata[10:0];
            REG_FACE_COUNT:   face_count_ff   <= pwdata[10:0];
            REG_SET_MASK:     set_mask_ff     <= pwdata[3:0];
            REG_DEGEN_LIMIT:  degen_limit_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_VERTEX_COUNT: prdata = 32'(vertex_count_ff);
         REG_FACE_COUNT:   prdata = 32'(face_count_ff);
         REG_SET_MASK:     prdata = 32'(set_mask_ff);
         REG_DEGEN_LIMIT:  prdata = degen_limit_ff;
         default:          prdata = '0;
      endcase
   end

   logic [16:0] vc_eff;
   logic [16:0] fc_eff;
   assign vc_eff = (17'(vertex_count_ff) > 17'(MAX_VERTICES)) ?
                   17'(MAX_VERTICES) : 17'(vertex_count_ff);
   assign fc_eff = (17'(face_count_ff) > 17'(MAX_FACES)) ?
                   17'(MAX_FACES) : 17'(face_count_ff);

   // handshake
   logic [NST-1:0] sv_ff;
   status_type     ss_ff [NST];
   logic           adv;
   logic           acc;
   logic           is_query;

   assign adv       = !sv_ff[NST-1] || rsp_ready;
   assign req_ready = adv && !reset;
   assign acc       = req_valid && req_ready;
   assign is_query  = (req_data.operation == OP_QUERY);

   // early checks
   logic       face_bad;
   logic       set_bad;
   status_type status_pre;

   assign face_bad = req_data.face_number[31] ||
                     (req_data.face_number[30:0] >= 31'(fc_eff)) || (vc_eff == '0);
   assign set_bad  = (32'(req_data.coord_set) >= COORD_SETS) ||
                     !set_mask_ff[req_data.coord_set];

   always_comb begin
      if (face_bad) begin
         status_pre = ST_BAD_FACE;
      end else if (set_bad) begin
         status_pre = ST_NO_SET;
      end else begin
         status_pre = ST_OK;
      end
   end

   // corner slot split into face and corner
   logic [23:0] q3_prod;
   logic [10:0] q3;
   logic [11:0] r3;
   logic [1:0]  kk;

   assign q3_prod = 24'(req_data.entry_index) * 24'(DIV3_MUL);
   assign q3      = q3_prod[23:DIV3_SHIFT];
   assign r3      = req_data.entry_index - (12'(q3) * 12'd3);
   assign kk      = r3[1:0];

   // tables: vertex/coord copies per corner; corner table banked by corner
   logic [95:0] vmem [3][MAX_VERTICES];
   logic [63:0] tmem [3][COORD_SETS][MAX_VERTICES];
   logic [15:0] cmem [3][MAX_FACES];

   logic [15:0]        crd_ff  [3];
   logic signed [31:0] hit1_ff [3];
   logic [1:0]         set1_ff;
   logic [95:0]        vrd_ff  [3];
   logic [63:0]        trd_ff  [3];
   logic signed [31:0] hit2_ff [3];

   always_ff @(posedge clock) begin
      if (acc) begin
         case (op_type'(req_data.operation))
            OP_LOAD_VERTEX: begin
               if (req_data.entry_index < MAX_VERTICES) begin
                  for (int k = 0; k < 3; k++) begin
                     vmem[k][VW'(req_data.entry_index)] <=
                        {req_data.value_z, req_data.value_y, req_data.value_x};
                  end
               end
            end
            OP_LOAD_COORD: begin
               if ((req_data.entry_index < MAX_VERTICES) &&
                   (32'(req_data.coord_set) < COORD_SETS)) begin
                  for (int k = 0; k < 3; k++) begin
                     tmem[k][SETW'(req_data.coord_set)][VW'(req_data.entry_index)] <=
                        {req_data.value_y, req_data.value_x};
                  end
               end
            end
            OP_LOAD_CORNER: begin
               if (req_data.entry_index < 3 * MAX_FACES) begin
                  for (int k = 0; k < 3; k++) begin
                     if (kk == 2'(k)) begin
                        cmem[k][FW'(q3)] <= req_data.vertex_ref;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            crd_ff[k] <= cmem[k][FW'(req_data.face_number)];
            vrd_ff[k] <= vmem[k][VW'(crd_ff[k])];
            trd_ff[k] <= tmem[k][SETW'(set1_ff)][VW'(crd_ff[k])];
         end
         hit1_ff[0] <= req_data.value_x;
         hit1_ff[1] <= req_data.value_y;
         hit1_ff[2] <= req_data.value_z;
         set1_ff    <= req_data.coord_set;
         hit2_ff    <= hit1_ff;
      end
   end

   logic ref_bad;
   always_comb begin
      ref_bad = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if ({1'b0, crd_ff[k]} >= vc_eff) begin
            ref_bad = 1'b1;
         end
      end
   end

   // edges, dot products
   logic signed [32:0] e0_ff  [3];
   logic signed [32:0] e1_ff  [3];
   logic signed [32:0] off_ff [3];
   logic signed [32:0] tl_ff  [6][6];
   logic signed [32:0] dva    [5][3];
   logic signed [32:0] dvb    [5][3];
   logic signed [65:0] pr_ff  [5][3];
   logic signed [67:0] dot_ff [5];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dva[0][c] = e0_ff[c];  dvb[0][c] = e0_ff[c];
         dva[1][c] = e0_ff[c];  dvb[1][c] = e1_ff[c];
         dva[2][c] = e1_ff[c];  dvb[2][c] = e1_ff[c];
         dva[3][c] = off_ff[c]; dvb[3][c] = e0_ff[c];
         dva[4][c] = off_ff[c]; dvb[4][c] = e1_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            e0_ff[c]  <= 33'(signed'(vrd_ff[1][32*c +: 32])) -
                         33'(signed'(vrd_ff[0][32*c +: 32]));
            e1_ff[c]  <= 33'(signed'(vrd_ff[2][32*c +: 32])) -
                         33'(signed'(vrd_ff[0][32*c +: 32]));
            off_ff[c] <= 33'(hit2_ff[c]) - 33'(signed'(vrd_ff[0][32*c +: 32]));
         end
         for (int c = 0; c < 2; c++) begin
            tl_ff[0][3*c]   <= 33'(signed'(trd_ff[0][32*c +: 32]));
            tl_ff[0][3*c+1] <= 33'(signed'(trd_ff[1][32*c +: 32])) -
                               33'(signed'(trd_ff[0][32*c +: 32]));
            tl_ff[0][3*c+2] <= 33'(signed'(trd_ff[2][32*c +: 32])) -
                               33'(signed'(trd_ff[0][32*c +: 32]));
         end
         for (int i = 1; i < 6; i++) begin
            tl_ff[i] <= tl_ff[i-1];
         end
         for (int d = 0; d < 5; d++) begin
            for (int c = 0; c < 3; c++) begin
               pr_ff[d][c] <= dva[d][c] * dvb[d][c];
            end
            dot_ff[d] <= 68'(pr_ff[d][0]) + 68'(pr_ff[d][1]) + 68'(pr_ff[d][2]);
         end
      end
   end

   // denominator and weight numerators
   logic signed [67:0]  ma [6];
   logic signed [67:0]  mb [6];
   logic signed [135:0] bp [6];

   always_comb begin
      ma[0] = dot_ff[0]; mb[0] = dot_ff[2];
      ma[1] = dot_ff[1]; mb[1] = dot_ff[1];
      ma[2] = dot_ff[2]; mb[2] = dot_ff[3];
      ma[3] = dot_ff[1]; mb[3] = dot_ff[4];
      ma[4] = dot_ff[0]; mb[4] = dot_ff[4];
      ma[5] = dot_ff[1]; mb[5] = dot_ff[3];
   end

   for (genvar g = 0; g < 6; g++) begin : g_wmul_a
      tuvbi_wmul #(.AW(68), .BW(68)) u_wmul (
         .clock (clock),
         .en    (adv),
         .a_in  (ma[g]),
         .b_in  (mb[g]),
         .p_out (bp[g])
      );
   end

   logic signed [DEN_W-1:0] den_ff;
   logic signed [DEN_W-1:0] n1_ff;
   logic signed [DEN_W-1:0] n2_ff;
   logic signed [DEN_W-1:0] dd_ff [3];
   logic                    degen;

   assign degen = (den_ff[DEN_W-1:32] == '0) && (den_ff[31:0] <= degen_limit_ff);

   // interpolation numerators
   logic signed [DEN_W-1:0]    na [6];
   logic signed [DEN_W+32:0]   tp [6];
   logic signed [NUM_W-1:0]    numu_ff;
   logic signed [NUM_W-1:0]    numv_ff;

   always_comb begin
      na[0] = den_ff; na[1] = n1_ff; na[2] = n2_ff;
      na[3] = den_ff; na[4] = n1_ff; na[5] = n2_ff;
   end

   for (genvar g = 0; g < 6; g++) begin : g_wmul_b
      tuvbi_wmul #(.AW(DEN_W), .BW(33)) u_wmul (
         .clock (clock),
         .en    (adv),
         .a_in  (na[g]),
         .b_in  (tl_ff[5][g]),
         .p_out (tp[g])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff   <= DEN_W'(bp[0]) - DEN_W'(bp[1]);
         n1_ff    <= DEN_W'(bp[2]) - DEN_W'(bp[3]);
         n2_ff    <= DEN_W'(bp[4]) - DEN_W'(bp[5]);
         dd_ff[0] <= den_ff;
         dd_ff[1] <= dd_ff[0];
         dd_ff[2] <= dd_ff[1];
         numu_ff  <= NUM_W'(tp[0]) + NUM_W'(tp[1]) + NUM_W'(tp[2]);
         numv_ff  <= NUM_W'(tp[3]) + NUM_W'(tp[4]) + NUM_W'(tp[5]);
      end
   end

   // rounding division
   logic signed [31:0] ures;
   logic signed [31:0] vres;

   tuvbi_div #(.NW(NUM_W), .DEN_W(DEN_W), .SW(SAT_W)) u_div_u (
      .clock   (clock),
      .en      (adv),
      .num_in  (numu_ff),
      .den_in  (dd_ff[2]),
      .res_out (ures)
   );

   tuvbi_div #(.NW(NUM_W), .DEN_W(DEN_W), .SW(SAT_W)) u_div_v (
      .clock   (clock),
      .en      (adv),
      .num_in  (numv_ff),
      .den_in  (dd_ff[2]),
      .res_out (vres)
   );

   // valid and status line
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
      end else if (adv) begin
         sv_ff <= {sv_ff[NST-2:0], acc && is_query};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ss_ff[0] <= status_pre;
         for (int i = 1; i < NST; i++) begin
            if ((i == 1) && (ss_ff[0] == ST_OK) && ref_bad) begin
               ss_ff[i] <= ST_BAD_REF;
            end else if ((i == 8) && (ss_ff[7] == ST_OK) && degen) begin
               ss_ff[i] <= ST_DEGEN;
            end else begin
               ss_ff[i] <= ss_ff[i-1];
            end
         end
      end
   end

   assign rsp_valid       = sv_ff[NST-1];
   assign rsp_data.status = ss_ff[NST-1];
   assign rsp_data.u_out  = (ss_ff[NST-1] == ST_OK) ? ures : '0;
   assign rsp_data.v_out  = (ss_ff[NST-1] == ST_OK) ? vres : '0;

`ifndef ASSERT_OFF
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input not ready with empty output");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sv_ff))
      else $error("pipeline moved during stall");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (acc && !is_query) |=> !sv_ff[0])
      else $error("load beat entered result path");
`endif

endmodule

>>> rtl/tuvbi_wmul.sv
// ----------------------------------------------------------------------------
// tuvbi_wmul
// Two-stage signed multiplier: 35x35 partial products, then a shifted sum.
// ----------------------------------------------------------------------------
module tuvbi_wmul #(
   parameter int AW = 68,
   parameter int BW = 68
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [AW-1:0]     a_in,
   input  logic signed [BW-1:0]     b_in,
   output logic signed [AW+BW-1:0]  p_out
);
   localparam int CW  = 34;
   localparam int NA  = (AW + CW - 1) / CW;
   localparam int NB  = (BW + CW - 1) / CW;
   localparam int XA  = NA * CW;
   localparam int XB  = NB * CW;
   localparam int PW  = AW + BW;
   localparam int PPW = 2 * CW + 2;

   logic signed [XA-1:0]  ax;
   logic signed [XB-1:0]  bx;
   logic signed [CW:0]    ca [NA];
   logic signed [CW:0]    cb [NB];
   logic signed [PPW-1:0] pp_ff [NA][NB];
   logic signed [PW-1:0]  sum_in;
   logic signed [PW-1:0]  p_ff;

   assign ax = XA'(a_in);
   assign bx = XB'(b_in);

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         ca[i] = {(i == NA - 1) ? ax[i*CW+CW-1] : 1'b0, ax[i*CW +: CW]};
      end
      for (int j = 0; j < NB; j++) begin
         cb[j] = {(j == NB - 1) ? bx[j*CW+CW-1] : 1'b0, bx[j*CW +: CW]};
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (PW'(pp_ff[i][j]) <<< (CW * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= ca[i] * cb[j];
            end
         end
         p_ff <= sum_in;
      end
   end

   assign p_out = p_ff;

endmodule

>>> rtl/tuvbi_div.sv
// ----------------------------------------------------------------------------
// tuvbi_div
// Pipelined rounding divider: round(num/den) to nearest, ties away from
// zero, saturated to SW signed bits; one quotient bit per stage.
// ----------------------------------------------------------------------------
module tuvbi_div #(
   parameter int NW    = 172,
   parameter int DEN_W = 137,
   parameter int SW    = 32
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NW-1:0]    num_in,
   input  logic signed [DEN_W-1:0] den_in,
   output logic signed [31:0]      res_out
);
   localparam int RW = NW + 2;

   logic [NW-1:0]   mag;
   logic [RW-1:0]   a_ff;
   logic [RW-1:0]   b_ff;
   logic            neg_ff [SW+2];
   logic [RW-1:0]   r_ff   [SW+1];
   logic [RW-1:0]   bs_ff  [SW+1];
   logic [SW-1:0]   q_ff   [SW+1];
   logic            ovf_ff [SW+1];
   logic [RW-1:0]   r_in   [SW];
   logic [SW-1:0]   q_in   [SW];
   logic [RW-1:0]   sh     [SW];
   logic [SW-1:0]   lim;
   logic [SW-1:0]   m;
   logic [31:0]     mm;
   logic signed [31:0] res_ff;

   assign mag = num_in[NW-1] ? NW'(-num_in) : NW'(num_in);

   always_comb begin
      for (int j = 0; j < SW; j++) begin
         sh[j]   = bs_ff[j] << (SW - 1 - j);
         r_in[j] = r_ff[j];
         q_in[j] = q_ff[j];
         if (r_ff[j] >= sh[j]) begin
            r_in[j] = r_ff[j] - sh[j];
            q_in[j][SW-1-j] = 1'b1;
         end
      end
   end

   assign lim = neg_ff[SW+1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
   assign m   = (ovf_ff[SW] || (q_ff[SW] > lim)) ? lim : q_ff[SW];
   assign mm  = 32'(m);

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff      <= RW'({mag, 1'b0}) + RW'($unsigned(den_in));
         b_ff      <= RW'({den_in, 1'b0});
         neg_ff[0] <= num_in[NW-1];
         r_ff[0]   <= a_ff;
         bs_ff[0]  <= b_ff;
         q_ff[0]   <= '0;
         ovf_ff[0] <= a_ff >= (b_ff << SW);
         neg_ff[1] <= neg_ff[0];
         for (int j = 0; j < SW; j++) begin
            r_ff[j+1]   <= r_in[j];
            q_ff[j+1]   <= q_in[j];
            bs_ff[j+1]  <= bs_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
            neg_ff[j+2] <= neg_ff[j+1];
         end
         res_ff <= neg_ff[SW+1] ? (32'd0 - mm) : mm;
      end
   end

   assign res_out = res_ff;

endmodule
